// ===== hdl/kclt_pkg.sv =====
// Shared types and constants for the keyed compacting list table.
`default_nettype none
package kclt_pkg;

   localparam int CAPACITY = 16;
   localparam int POS_W    = 4;
   localparam int CNT_W    = 5;
   localparam int KEY_W    = 16;
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hdl/kclt_ctrl.sv =====
// Controller state machine: sequences capture and execution of one request beat.
`default_nettype none
module kclt_ctrl
   import kclt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd,
   output logic         rsp_strobe
);

   state_type state_ff, state_in;
   logic      rsp_strobe_ff, rsp_strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      rsp_strobe_in = 1'b0;
      busy          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            busy          = 1'b1;
            cmd.execute   = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;

endmodule
`default_nettype wire

// ===== hdl/kclt_datapath.sv =====
// Datapath: entry registers, parallel key compare, compaction shift and response registers.
`default_nettype none
module kclt_datapath
   import kclt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   input  wire logic [1:0]        req_action,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [DATA_W-1:0] req_entry_data,
   input  wire logic [POS_W-1:0]  req_position,
   output logic [1:0]             rsp_status,
   output logic [POS_W-1:0]       rsp_found_position,
   output logic [KEY_W-1:0]       rsp_found_key,
   output logic [DATA_W-1:0]      rsp_found_data,
   output logic [CNT_W-1:0]       rsp_entry_count
);

   // Captured request beat.
   action_type        action_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] data_ff;
   logic [POS_W-1:0]  pos_ff;

   // Table contents and fill count.
   logic [KEY_W-1:0]  key_store_ff  [CAPACITY];
   logic [DATA_W-1:0] data_store_ff [CAPACITY];
   logic [CNT_W-1:0]  count_ff, count_in;

   // Response registers.
   status_type        status_ff, status_in;
   logic [POS_W-1:0]  rpos_ff, rpos_in;
   logic [KEY_W-1:0]  rkey_ff, rkey_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;

   logic [CAPACITY-1:0] match;
   logic                hit;
   logic [POS_W-1:0]    match_idx;
   logic [POS_W-1:0]    sel_idx;
   logic                full;
   logic                pos_ok;
   logic                do_append;
   logic                do_remove;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= action_type'(req_action);
         key_ff    <= req_key;
         data_ff   <= req_entry_data;
         pos_ff    <= req_position;
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (key_store_ff[i] == key_ff);
      end
   end

   // Lowest matching position wins.
   always_comb begin
      hit       = 1'b0;
      match_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match[i] && !hit) begin
            hit       = 1'b1;
            match_idx = POS_W'(i);
         end
      end
   end

   assign sel_idx   = (action_ff == ACT_READ) ? pos_ff : match_idx;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign pos_ok    = ({1'b0, pos_ff} < count_ff);
   assign do_append = cmd.execute && (action_ff == ACT_APPEND) && !full;
   assign do_remove = cmd.execute && (action_ff == ACT_REMOVE) && hit;

   always_comb begin
      status_in = ST_MISS;
      rpos_in   = '0;
      rkey_in   = '0;
      rdata_in  = '0;
      count_in  = count_ff;
      case (action_ff)
         ACT_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_OK;
               rpos_in   = count_ff[POS_W-1:0];
               rkey_in   = key_ff;
               rdata_in  = data_ff;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         ACT_SEARCH, ACT_REMOVE: begin
            if (hit) begin
               status_in = ST_OK;
               rpos_in   = match_idx;
               rkey_in   = key_store_ff[sel_idx];
               rdata_in  = data_store_ff[sel_idx];
               if (action_ff == ACT_REMOVE) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         ACT_READ: begin
            if (pos_ok) begin
               status_in = ST_OK;
               rpos_in   = pos_ff;
               rkey_in   = key_store_ff[sel_idx];
               rdata_in  = data_store_ff[sel_idx];
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         rpos_ff   <= rpos_in;
         rkey_ff   <= rkey_in;
         rdata_ff  <= rdata_in;
      end
   end

   // Each entry loads either the appended record or its upper neighbor on a remove.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (do_append && (count_ff[POS_W-1:0] == POS_W'(i))) begin
            key_store_ff[i]  <= key_ff;
            data_store_ff[i] <= data_ff;
         end else if (do_remove && (i < CAPACITY - 1) && (POS_W'(i) >= match_idx)) begin
            key_store_ff[i]  <= key_store_ff[(i + 1) % CAPACITY];
            data_store_ff[i] <= data_store_ff[(i + 1) % CAPACITY];
         end
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_found_position = rpos_ff;
   assign rsp_found_key      = rkey_ff;
   assign rsp_found_data     = rdata_ff;
   assign rsp_entry_count    = count_ff;

endmodule
`default_nettype wire

// ===== hdl/keyed_compacting_list_table.sv =====
// Top level of the keyed compacting list table: controller, datapath and checks.
// Each request beat is captured on the edge where start is high and busy low; busy stays
// high for one execute cycle in which all sixteen keys are compared at once and a remove
// shifts the later entries down in that same cycle, and rsp_strobe marks the response in
// the cycle after. A new start is taken in the cycle the response is shown. The receiver
// cannot stall; rsp_strobe is high for a single cycle per response, and the rsp_ ports
// hold it until another request executes. The table holds sixteen entries.
`default_nettype none
module keyed_compacting_list_table
   import kclt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_action,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [DATA_W-1:0] req_entry_data,
   input  wire logic [POS_W-1:0]  req_position,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [POS_W-1:0]       rsp_found_position,
   output logic [KEY_W-1:0]       rsp_found_key,
   output logic [DATA_W-1:0]      rsp_found_data,
   output logic [CNT_W-1:0]       rsp_entry_count
);

   cmd_type cmd;

   kclt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   kclt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_action         (req_action),
      .req_key            (req_key),
      .req_entry_data     (req_entry_data),
      .req_position       (req_position),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_found_key      (rsp_found_key),
      .rsp_found_data     (rsp_found_data),
      .rsp_entry_count    (rsp_entry_count)
   );

`ifndef NO_ASSERTIONS
   a_exec_then_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("execute cycle not followed by a response beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entry_count <= CNT_W'(CAPACITY)))
      else $error("entry count beyond capacity");

   a_full_only_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_FULL)) |-> (rsp_entry_count == CNT_W'(CAPACITY)))
      else $error("full status reported below capacity");

   a_count_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy && $past(!busy) && !rsp_strobe) |-> $stable(rsp_entry_count))
      else $error("entry count changed without a request beat");
`endif

endmodule
`default_nettype wire

// ===== tb/kclt_checker.sv =====
// Response checker for the keyed compacting list table: shadow table, expected queue, compare.
`timescale 1ns / 100ps
module kclt_checker
   import kclt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic [1:0]        req_action,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [DATA_W-1:0] req_entry_data,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic              rsp_strobe,
   input  wire logic [1:0]        rsp_status,
   input  wire logic [POS_W-1:0]  rsp_found_position,
   input  wire logic [KEY_W-1:0]  rsp_found_key,
   input  wire logic [DATA_W-1:0] rsp_found_data,
   input  wire logic [CNT_W-1:0]  rsp_entry_count,
   output int                     error_count,
   output int                     pending_count,
   output int                     result_count,
   output int                     full_count,
   output int                     miss_count
);

   typedef struct {
      status_type        status;
      logic [POS_W-1:0]  position;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
      logic [CNT_W-1:0]  count;
   } lookup_result_type;

   logic [KEY_W-1:0]  shadow_keys [CAPACITY];
   logic [DATA_W-1:0] shadow_data [CAPACITY];
   int                shadow_count;
   lookup_result_type expected_results [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      result_count  = 0;
      full_count    = 0;
      miss_count    = 0;
      shadow_count  = 0;
   end

   // Applies one request beat to the shadow table and queues the response it must produce.
   task automatic predict_lookup(input action_type act, input logic [KEY_W-1:0] k,
                                 input logic [DATA_W-1:0] d, input logic [POS_W-1:0] p);
      lookup_result_type r;
      int                hit;
      r.status   = ST_MISS;
      r.position = '0;
      r.key      = '0;
      r.data     = '0;
      hit        = -1;
      case (act)
         ACT_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               shadow_keys[shadow_count] = k;
               shadow_data[shadow_count] = d;
               r.status   = ST_OK;
               r.position = POS_W'(shadow_count);
               r.key      = k;
               r.data     = d;
               shadow_count++;
            end
         end
         ACT_SEARCH, ACT_REMOVE: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (hit < 0 && shadow_keys[i] == k) hit = i;
            end
            if (hit >= 0) begin
               r.status   = ST_OK;
               r.position = POS_W'(hit);
               r.key      = shadow_keys[hit];
               r.data     = shadow_data[hit];
               if (act == ACT_REMOVE) begin
                  // Later entries close the gap; the freed top slot keeps stale contents.
                  for (int i = hit; i + 1 < shadow_count; i++) begin
                     shadow_keys[i] = shadow_keys[i + 1];
                     shadow_data[i] = shadow_data[i + 1];
                  end
                  shadow_count--;
               end
            end
         end
         default: begin
            if (int'(p) < shadow_count) begin
               r.status   = ST_OK;
               r.position = p;
               r.key      = shadow_keys[p];
               r.data     = shadow_data[p];
            end
         end
      endcase
      r.count = CNT_W'(shadow_count);
      expected_results.push_back(r);
   endtask

   task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_value,
                                input logic [DATA_W-1:0] act_value);
      if (act_value !== exp_value) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_value,
                  act_value);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      lookup_result_type e;
      if (!reset) begin
         // The response leaving at this edge belongs to an earlier beat, so it is matched first.
         if (rsp_strobe === 1'b1) begin
            result_count++;
            if (expected_results.size() == 0) begin
               $display("%0t: response beat with no request outstanding, status %h key %h",
                        $time, rsp_status, rsp_found_key);
               error_count++;
            end else begin
               e = expected_results.pop_front();
               if (e.status == ST_FULL) full_count++;
               if (e.status == ST_MISS) miss_count++;
               compare_field("status", DATA_W'(e.status), DATA_W'(rsp_status));
               compare_field("found_position", DATA_W'(e.position),
                             DATA_W'(rsp_found_position));
               compare_field("found_key", DATA_W'(e.key), DATA_W'(rsp_found_key));
               compare_field("found_data", e.data, rsp_found_data);
               compare_field("entry_count", DATA_W'(e.count), DATA_W'(rsp_entry_count));
            end
         end
         if (start && !busy) begin
            predict_lookup(action_type'(req_action), req_key, req_entry_data, req_position);
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

// ===== tb/tb_keyed_compacting_list_table.sv =====
// Testbench top for the keyed compacting list table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_keyed_compacting_list_table
   import kclt_pkg::*;
();

   localparam int RANDOM_ITEMS = 850;
   localparam int STALL_LIMIT  = 500;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_action = '0;
   logic [KEY_W-1:0]  req_key = '0;
   logic [DATA_W-1:0] req_entry_data = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic              rsp_strobe;
   logic [1:0]        rsp_status;
   logic [POS_W-1:0]  rsp_found_position;
   logic [KEY_W-1:0]  rsp_found_key;
   logic [DATA_W-1:0] rsp_found_data;
   logic [CNT_W-1:0]  rsp_entry_count;

   int error_count;
   int pending_count;
   int result_count;
   int full_count;
   int miss_count;
   int beats_sent = 0;
   int stall_cycles = 0;
   bit no_gaps = 1'b0;
   logic [KEY_W-1:0] key_pool [6];

   always #4 clock = ~clock;

   keyed_compacting_list_table uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_key            (req_key),
      .req_entry_data     (req_entry_data),
      .req_position       (req_position),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_found_key      (rsp_found_key),
      .rsp_found_data     (rsp_found_data),
      .rsp_entry_count    (rsp_entry_count)
   );

   kclt_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_key            (req_key),
      .req_entry_data     (req_entry_data),
      .req_position       (req_position),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_found_key      (rsp_found_key),
      .rsp_found_data     (rsp_found_data),
      .rsp_entry_count    (rsp_entry_count),
      .error_count        (error_count),
      .pending_count      (pending_count),
      .result_count       (result_count),
      .full_count         (full_count),
      .miss_count         (miss_count)
   );

   // Called right after an edge; returns at the edge that accepts the beat.
   task automatic issue_request(input action_type act, input logic [KEY_W-1:0] k,
                                input logic [DATA_W-1:0] d, input logic [POS_W-1:0] p);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_key        <= k;
      req_entry_data <= d;
      req_position   <= p;
      do @(posedge clock); while (busy !== 1'b0);
      beats_sent++;
   endtask

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int               append_pct;
      int               remove_pct;
      int               draw;
      action_type       act;
      logic [KEY_W-1:0] k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extreme keys and data, duplicates, full table, shifts.
      issue_request(ACT_READ, 16'h0000, 32'h0, 4'd0);
      issue_request(ACT_SEARCH, 16'h0000, 32'h0, 4'd0);
      issue_request(ACT_REMOVE, 16'hFFFF, 32'h0, 4'd15);
      issue_request(ACT_APPEND, 16'h0000, 32'h0000_0000, 4'd0);
      issue_request(ACT_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 4'd15);
      issue_request(ACT_APPEND, 16'h5A5A, 32'hA5A5_A5A5, 4'd0);
      issue_request(ACT_APPEND, 16'h5A5A, 32'h1234_5678, 4'd0);
      for (int i = 4; i < CAPACITY; i++) begin
         issue_request(ACT_APPEND, 16'h0100 + KEY_W'(i), $urandom, 4'd0);
      end
      issue_request(ACT_APPEND, 16'hBEEF, 32'hDEAD_BEEF, 4'd0);
      issue_request(ACT_READ, 16'h0000, 32'h0, 4'd15);
      issue_request(ACT_SEARCH, 16'h5A5A, 32'h0, 4'd0);
      issue_request(ACT_REMOVE, 16'h0000, 32'h0, 4'd0);
      issue_request(ACT_REMOVE, 16'hFFFF, 32'h0, 4'd0);
      issue_request(ACT_REMOVE, 16'h010F, 32'h0, 4'd0);
      issue_request(ACT_READ, 16'h0000, 32'h0, 4'd13);
      issue_request(ACT_READ, 16'h0000, 32'h0, 4'd12);

      foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 65535));
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;

      // Random: phases that lean toward filling, draining or a mix, keys mostly from a pool.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (n % 100 == 99) key_pool[$urandom_range(0, 5)] = KEY_W'($urandom_range(0, 65535));
         case ((n / 60) % 3)
            0:       begin append_pct = 75; remove_pct = 5;  end
            1:       begin append_pct = 15; remove_pct = 55; end
            default: begin append_pct = 35; remove_pct = 25; end
         endcase
         draw = $urandom_range(0, 99);
         if (draw < append_pct) act = ACT_APPEND;
         else if (draw < append_pct + remove_pct) act = ACT_REMOVE;
         else if (draw < append_pct + remove_pct + (100 - append_pct - remove_pct) / 2)
            act = ACT_SEARCH;
         else act = ACT_READ;
         if ($urandom_range(0, 4) == 0) k = KEY_W'($urandom_range(0, 65535));
         else k = key_pool[$urandom_range(0, 5)];
         issue_request(act, k, $urandom, POS_W'($urandom_range(0, 15)));
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d request beats and checked %0d responses.", beats_sent, result_count);
      $display("Responses included %0d table-full and %0d miss outcomes.", full_count,
               miss_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches found.", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/kclt_pkg.sv
hdl/kclt_ctrl.sv
hdl/kclt_datapath.sv
hdl/keyed_compacting_list_table.sv
tb/kclt_checker.sv
tb/tb_keyed_compacting_list_table.sv
